FILE: hw/rtl/svsa_pkg.sv
// Shared types and codes for the voice slot allocator.
`default_nettype none
package svsa_pkg;

	// Operation codes of a request word
	localparam logic [1:0] OP_PLAY   = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Status codes of a response word
	localparam logic [2:0] ST_FREE     = 3'd0;
	localparam logic [2:0] ST_REPLACED = 3'd1;
	localparam logic [2:0] ST_REMOVED  = 3'd2;
	localparam logic [2:0] ST_TIME     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// One voice slot as held in the entry RAM
	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] sound;
		logic [31:0] handle;
		logic [31:0] start;
	} entry_t;

	// Store port controls from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic vld_set;
		logic vld_clr;
	} store_ctl_t;

	// Victim tracker controls from the sequencer
	typedef struct packed {
		logic clear;
		logic update;
	} trk_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/svsa_req_if.sv
// Request channel: valid/ready with the request word fields.
`default_nettype none
interface svsa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  priority_req;
	logic [15:0] sound_id;
	logic [31:0] handle_id;
	logic [31:0] now_ms;

	modport source (output valid, opcode, priority_req, sound_id, handle_id, now_ms,
		input ready);
	modport sink (input valid, opcode, priority_req, sound_id, handle_id, now_ms,
		output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/svsa_rsp_if.sv
// Response channel: valid/ready with the response word fields.
`default_nettype none
interface svsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot_index;
	logic [15:0] evicted_sound_id;
	logic [31:0] evicted_handle;
	logic [31:0] elapsed_ms;

	modport source (output valid, status, slot_index, evicted_sound_id, evicted_handle,
		elapsed_ms, input ready);
	modport sink (input valid, status, slot_index, evicted_sound_id, evicted_handle,
		elapsed_ms, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/sound_voice_slot_allocator.sv
// Top level: voice slot allocator with a one-slot-per-cycle scan sequencer.
// Flow: a request scans the slots in order and stops at the first hit; a remove or query
// that misses answers after the last slot; a play that steals fetches the victim first.
// Throughput: one request at a time, set by the sequencer, which takes requests only while idle;
// a new request is taken the cycle after the response word is loaded.
// Reset: arst_n empties the table (valid flops only) and idles the sequencer.
`default_nettype none
module sound_voice_slot_allocator import svsa_pkg::*; #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	svsa_req_if.sink   req,
	svsa_rsp_if.source rsp
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int XW = (IW > 4) ? IW : 4;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_FWAIT = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;       // next slot to read
	logic          s1_vld_q;    // read data in flight for slot s1_idx_s1
	logic [IW-1:0] s1_idx_s1;

	// Captured request word
	logic [1:0]    op_q;
	logic [7:0]    prio_q;
	logic [15:0]   snd_q;
	logic [31:0]   handle_q;
	logic [31:0]   now_q;

	// Scan results
	logic          hit_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   elapsed_q;
	logic [15:0]   ev_snd_q;
	logic [31:0]   ev_h_q;

	// Response register
	logic          rsp_vld_q;
	logic [2:0]    rsp_status_q;
	logic [3:0]    rsp_idx_q;
	logic [15:0]   rsp_ev_snd_q;
	logic [31:0]   rsp_ev_h_q;
	logic [31:0]   rsp_elapsed_q;

	logic          accept;
	logic          scan_issue;
	logic          eval;
	logic          ent_hit;
	logic          last;
	logic          load;
	logic          is_play;
	logic [2:0]    status_d;
	logic [XW-1:0] idx_ext;

	store_ctl_t    st_ctl;
	trk_ctl_t      trk_ctl;
	logic [IW-1:0] rd_addr;
	entry_t        rd_data;
	entry_t        wr_data;
	logic          vld_rd;
	logic [IW-1:0] victim;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_play   = (op_q == OP_PLAY);

	// Issue one RAM read per cycle until every slot has been requested
	assign scan_issue = (state_q == S_SCAN) && (cnt_q < CW'(TABLE_SLOTS));
	assign eval       = (state_q == S_SCAN) && s1_vld_q;
	assign last       = (s1_idx_s1 == IW'(TABLE_SLOTS - 1));

	// Play looks for a free slot; remove and query for a live slot with the handle
	assign ent_hit = is_play ? !vld_rd : (vld_rd && (rd_data.handle == handle_q));

	// Response register takes a word when empty or being drained
	assign load = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		status_d = ST_NOTFOUND;
		unique case (op_q)
			OP_PLAY:   status_d = hit_q ? ST_FREE : ST_REPLACED;
			OP_REMOVE: status_d = hit_q ? ST_REMOVED : ST_NOTFOUND;
			OP_QUERY:  status_d = hit_q ? ST_TIME : ST_NOTFOUND;
			default:   status_d = ST_NOTFOUND;
		endcase
	end

	assign idx_ext = XW'(idx_q);

	// Store controls: scan reads, victim fetch, commit on the finishing cycle
	always_comb begin
		st_ctl.rd_en   = scan_issue || (state_q == S_FETCH);
		st_ctl.wr_en   = load && is_play;
		st_ctl.vld_set = load && is_play;
		st_ctl.vld_clr = load && (op_q == OP_REMOVE) && hit_q;
		rd_addr        = (state_q == S_FETCH) ? victim : cnt_q[IW-1:0];
	end

	assign wr_data = '{prio: prio_q, sound: snd_q, handle: handle_q, start: now_q};

	// Tracker sees each occupied slot that a play scan reads before it finds a free one
	always_comb begin
		trk_ctl.clear  = accept;
		trk_ctl.update = eval && is_play && vld_rd;
	end

	svsa_slot_store #(
		.SLOTS (TABLE_SLOTS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_addr  (idx_q),
		.wr_data  (wr_data),
		.vld_addr (s1_idx_s1),
		.vld_rd   (vld_rd)
	);

	svsa_victim_track #(
		.SLOTS (TABLE_SLOTS)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (trk_ctl),
		.idx      (s1_idx_s1),
		.prio_req (prio_q),
		.ent      (rd_data),
		.victim   (victim)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			s1_vld_q  <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			rsp_vld_q <= load || (rsp_vld_q && !rsp.ready);
			unique case (state_q)
				S_IDLE: begin
					cnt_q    <= '0;
					s1_vld_q <= 1'b0;
					if (accept) begin
						// Unused opcode goes straight to the answer
						if (req.opcode == OP_PLAY || req.opcode == OP_REMOVE ||
							req.opcode == OP_QUERY) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					s1_vld_q <= scan_issue;
					if (scan_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (eval && ent_hit) begin
						state_q <= S_DONE;
					end else if (eval && last) begin
						state_q <= is_play ? S_FETCH : S_DONE;
					end
				end
				S_FETCH: state_q <= S_FWAIT;
				S_FWAIT: state_q <= S_DONE;
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request capture and scan results
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			s1_idx_s1 <= cnt_q[IW-1:0];
		end
		if (accept) begin
			op_q      <= req.opcode;
			prio_q    <= req.priority_req;
			snd_q     <= req.sound_id;
			handle_q  <= req.handle_id;
			now_q     <= req.now_ms;
			hit_q     <= 1'b0;
			idx_q     <= '0;
			elapsed_q <= '0;
			ev_snd_q  <= '0;
			ev_h_q    <= '0;
		end
		if (eval && ent_hit) begin
			hit_q     <= 1'b1;
			idx_q     <= s1_idx_s1;
			elapsed_q <= now_q - rd_data.start;
		end
		if (state_q == S_FETCH) begin
			idx_q <= victim;
		end
		if (state_q == S_FWAIT) begin
			ev_snd_q <= rd_data.sound;
			ev_h_q   <= rd_data.handle;
		end
	end

	// Response word: zero every field the status does not use
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_status_q  <= status_d;
			rsp_idx_q     <= (hit_q || is_play) ? idx_ext[3:0] : 4'd0;
			rsp_ev_snd_q  <= (is_play && !hit_q) ? ev_snd_q : 16'd0;
			rsp_ev_h_q    <= (is_play && !hit_q) ? ev_h_q : 32'd0;
			rsp_elapsed_q <= ((op_q == OP_QUERY) && hit_q) ? elapsed_q : 32'd0;
		end
	end

	assign rsp.valid            = rsp_vld_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.slot_index       = rsp_idx_q;
	assign rsp.evicted_sound_id = rsp_ev_snd_q;
	assign rsp.evicted_handle   = rsp_ev_h_q;
	assign rsp.elapsed_ms       = rsp_elapsed_q;

endmodule
`default_nettype wire

FILE: hw/rtl/svsa_slot_store.sv
// Slot store: entry RAM with registered read and per-slot valid flops.
`default_nettype none
module svsa_slot_store import svsa_pkg::*; #(
	parameter int SLOTS = 16,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire store_ctl_t     ctl,
	input  wire logic [IW-1:0]  rd_addr,
	output      entry_t         rd_data,
	input  wire logic [IW-1:0]  wr_addr,
	input  wire entry_t         wr_data,
	input  wire logic [IW-1:0]  vld_addr,
	output      logic           vld_rd
);

	entry_t            mem_q [SLOTS];
	entry_t            rd_data_q;
	logic [SLOTS-1:0]  vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Valid bits: table starts empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.vld_set) begin
			vld_q[wr_addr] <= 1'b1;
		end else if (ctl.vld_clr) begin
			vld_q[wr_addr] <= 1'b0;
		end
	end

	assign rd_data = rd_data_q;
	assign vld_rd  = vld_q[vld_addr];

endmodule
`default_nettype wire

FILE: hw/rtl/svsa_victim_track.sv
// Victim tracker: oldest slot of the requested priority and oldest overall.
`default_nettype none
module svsa_victim_track import svsa_pkg::*; #(
	parameter int SLOTS = 16,
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire trk_ctl_t      ctl,
	input  wire logic [IW-1:0] idx,
	input  wire logic [7:0]    prio_req,
	input  wire entry_t        ent,
	output      logic [IW-1:0] victim
);

	logic          have_p_q;
	logic          have_a_q;
	logic [IW-1:0] best_p_idx_q;
	logic [IW-1:0] best_a_idx_q;
	logic [31:0]   best_p_start_q;
	logic [31:0]   best_a_start_q;
	logic          take_p;
	logic          take_a;

	// Strict less-than keeps the lowest index on a tie
	assign take_p = (ent.prio == prio_req) && (!have_p_q || (ent.start < best_p_start_q));
	assign take_a = !have_a_q || (ent.start < best_a_start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_p_q <= 1'b0;
			have_a_q <= 1'b0;
		end else if (ctl.clear) begin
			have_p_q <= 1'b0;
			have_a_q <= 1'b0;
		end else if (ctl.update) begin
			if (take_p) begin
				have_p_q <= 1'b1;
			end
			have_a_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.update && !ctl.clear) begin
			if (take_p) begin
				best_p_idx_q   <= idx;
				best_p_start_q <= ent.start;
			end
			if (take_a) begin
				best_a_idx_q   <= idx;
				best_a_start_q <= ent.start;
			end
		end
	end

	assign victim = have_p_q ? best_p_idx_q : best_a_idx_q;

endmodule
`default_nettype wire
